[design/cppm_pkg.sv]
// Shared types, constants, node tables and saturating add for the cubic prism point mapper.
package cppm_pkg;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic ov;
    logic signed [63:0] v;
  } sat_t;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  localparam int NUM_NODES  = 40;
  localparam int NUM_AXES   = 3;
  localparam int NUM_LAYERS = 4;
  localparam int NUM_COEF   = 10;
  localparam int NUM_LANES  = NUM_AXES * NUM_LAYERS;
  localparam int NUM_ENTRY  = NUM_LANES * NUM_COEF;
  localparam int NODE_W     = 32;
  localparam int COEF_W     = 40;
  localparam int ACC_W      = 42;

  // node of each layer feeding each local position
  localparam logic [5:0] LAYER_NODES [NUM_LAYERS][NUM_COEF] = '{
    '{6'd0,  6'd1,  6'd2,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd24},
    '{6'd12, 6'd14, 6'd16, 6'd25, 6'd26, 6'd29, 6'd30, 6'd33, 6'd34, 6'd38},
    '{6'd13, 6'd15, 6'd17, 6'd28, 6'd27, 6'd32, 6'd31, 6'd36, 6'd35, 6'd39},
    '{6'd3,  6'd4,  6'd5,  6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd37}};

  // twice each modal coefficient as a combination of the ten layer nodes
  localparam logic signed [7:0] TWICE_W [NUM_COEF][NUM_COEF] = '{
    '{8'sd2,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{-8'sd11, 8'sd2,   8'sd0,   8'sd18,  -8'sd9,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{-8'sd11, 8'sd0,   8'sd2,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   -8'sd9,  8'sd18,  8'sd0},
    '{8'sd18,  -8'sd9,  8'sd0,   -8'sd45, 8'sd36,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{8'sd36,  8'sd0,   8'sd0,   -8'sd45, 8'sd9,   -8'sd9,  -8'sd9,  8'sd9,   -8'sd45, 8'sd54},
    '{8'sd18,  8'sd0,   -8'sd9,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd36,  -8'sd45, 8'sd0},
    '{-8'sd9,  8'sd9,   8'sd0,   8'sd27,  -8'sd27, 8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0},
    '{-8'sd27, 8'sd0,   8'sd0,   8'sd54,  -8'sd27, 8'sd27,  8'sd0,   8'sd0,   8'sd27,  -8'sd54},
    '{-8'sd27, 8'sd0,   8'sd0,   8'sd27,  8'sd0,   8'sd0,   8'sd27,  -8'sd27, 8'sd54,  -8'sd54},
    '{-8'sd9,  8'sd0,   8'sd9,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   -8'sd27, 8'sd27,  8'sd0}};

  function automatic sat_t sat_add(input s64_t a, input s64_t b);
    sat_t r;
    s64_t s;
    s = a + b;
    r.ov = 1'b0;
    r.v  = s;
    if (!a[63] && !b[63] && s[63]) begin
      r.ov = 1'b1;
      r.v  = {1'b0, {63{1'b1}}};
    end else if (a[63] && b[63] && !s[63]) begin
      r.ov = 1'b1;
      r.v  = {1'b1, 63'd0};
    end
    return r;
  endfunction

endpackage

[design/cppm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cppm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/cppm_mul_shift.sv]
// Four-stage signed 64x64 multiply, rounding right shift and 64-bit saturation.
module cppm_mul_shift #(
  parameter int FRAC = 30
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               ov_in,
  output logic signed [63:0] p,
  output logic               ov_out
);

  localparam logic [127:0] RND = 128'd1 << (FRAC - 1);
  localparam logic [127:0] POS_LIM = (128'd1 << 63) - 128'd1;
  localparam logic [127:0] NEG_LIM = 128'd1 << 63;

  logic [63:0]  ua_r, ub_r;
  logic         neg1_r, ov1_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg2_r, ov2_r;
  logic [127:0] prod_r;
  logic         neg3_r, ov3_r;
  logic signed [63:0] p_r, p_nxt;
  logic         ov_r, ov_nxt;
  logic [127:0] q;

  always_comb begin
    q = prod_r >> FRAC;
    ov_nxt = ov3_r;
    if (q > (neg3_r ? NEG_LIM : POS_LIM)) begin
      ov_nxt = 1'b1;
      p_nxt  = neg3_r ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      p_nxt = neg3_r ? -$signed(q[63:0]) : $signed(q[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);
      neg1_r <= a[63] ^ b[63];
      ov1_r  <= ov_in;
      p00_r  <= 64'(ua_r[31:0]) * 64'(ub_r[31:0]);
      p01_r  <= 64'(ua_r[31:0]) * 64'(ub_r[63:32]);
      p10_r  <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      p11_r  <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      neg2_r <= neg1_r;
      ov2_r  <= ov1_r;
      prod_r <= {p11_r, 64'd0} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
                + {64'd0, p00_r} + RND;
      neg3_r <= neg2_r;
      ov3_r  <= ov2_r;
      p_r    <= p_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign p      = p_r;
  assign ov_out = ov_r;

endmodule

[design/cubic_prism_point_mapper.sv]
// Top level: 40-node cubic prism mapper with node RAM, commit sequencer and point pipeline.
//
//  channel | dir | fields (tdata / tuser, low bits first)
//  in_*    | in  | tdata: node_index, axis_index, node_value, param_u, param_v, param_w
//          |     | tuser: command
//  out_*   | out | tdata: coord_x, coord_y, coord_z;  tuser: overflow
//
// Evaluate, load and unknown commands are taken one per cycle while the output is not stalled
// and no commit is running; an evaluate result's depth is set by the multiply chain (four
// 4-stage multiplies deep). A commit waits for in-flight evaluations to drain, then sweeps
// the node RAM one read per cycle, 120 reads in all, during which no input is taken.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the coefficients to zero and the node RAM is left unset.
module cubic_prism_point_mapper #(
  parameter int PARAM_FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // node_index[5:0], axis_index[7:6], node_value[39:8],
                                   // param_u[71:40], param_v[103:72], param_w[135:104]
  input  logic [1:0]   in_tuser,   // command[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  output logic         out_tuser   // overflow
);

  import cppm_pkg::*;

  localparam int PIPE_DEPTH = 27;
  localparam int U_DLY      = 13;
  localparam int DIV_ST     = 8;
  localparam int ADDR_W     = $clog2(NUM_ENTRY);
  localparam logic [3:0] LAST_LAY = 4'(NUM_LANES - 1);
  localparam logic [3:0] LAST_J   = 4'(NUM_COEF - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam s64_t ONE = s64_t'(1) <<< PARAM_FRAC_BITS;

  // input fields
  logic [5:0]         in_node;
  logic [1:0]         in_axis;
  logic signed [31:0] in_value, in_u, in_v, in_w;
  assign in_node  = in_tdata[5:0];
  assign in_axis  = in_tdata[7:6];
  assign in_value = in_tdata[39:8];
  assign in_u     = in_tdata[71:40];
  assign in_v     = in_tdata[103:72];
  assign in_w     = in_tdata[135:104];

  logic [1:0]            state_r, state_nxt;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  adv, in_xfer;

  assign adv        = !vld_r[PIPE_DEPTH-1] | out_tready;
  assign in_tready  = adv & (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_xfer && (in_tuser == CMD_EVAL)};
    end
  end

  // ---------------------------------------------------------------- node RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  logic [3:0]        lay_r, j_r;

  assign ram_we    = in_xfer && (in_tuser == CMD_LOAD) && (in_node < 6'(NUM_NODES))
                     && (in_axis < 2'(NUM_AXES));
  assign ram_waddr = ADDR_W'(in_axis) * ADDR_W'(NUM_NODES) + ADDR_W'(in_node);
  assign ram_raddr = ADDR_W'(lay_r[3:2]) * ADDR_W'(NUM_NODES)
                     + ADDR_W'(LAYER_NODES[lay_r[1:0]][j_r]);

  cppm_ram #(.WIDTH(NODE_W), .DEPTH(NUM_ENTRY)) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- commit sequencer
  logic                     rd_vld_r, fin_vld_r;
  logic [3:0]               rd_lay_r, rd_j_r, fin_lay_r;
  logic signed [ACC_W-1:0]  acc_r [NUM_COEF];
  logic signed [ACC_W-1:0]  fin_r [NUM_COEF];
  logic signed [ACC_W-1:0]  acc_nxt [NUM_COEF];
  logic signed [COEF_W-1:0] rnd [NUM_COEF];
  logic signed [COEF_W-1:0] coef_r [NUM_ENTRY];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer && (in_tuser == CMD_COMMIT)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (vld_r == '0) state_nxt = ST_SWEEP;
      ST_SWEEP: if ((lay_r == LAST_LAY) && (j_r == LAST_J)) state_nxt = ST_FLUSH;
      ST_FLUSH: if (fin_vld_r && (fin_lay_r == LAST_LAY)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] q;
    for (int k = 0; k < NUM_COEF; k++) begin
      acc_nxt[k] = ((rd_j_r == 4'd0) ? ACC_W'(0) : acc_r[k])
                   + ACC_W'(TWICE_W[k][rd_j_r]) * ACC_W'($signed(ram_rdata));
      // halve, rounding half away from zero
      m = fin_r[k][ACC_W-1] ? ACC_W'(-fin_r[k]) : ACC_W'(fin_r[k]);
      q = (m + ACC_W'(1)) >> 1;
      rnd[k] = fin_r[k][ACC_W-1] ? -$signed(q[COEF_W-1:0]) : $signed(q[COEF_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lay_r     <= '0;
      j_r       <= '0;
      rd_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
      for (int e = 0; e < NUM_ENTRY; e++) coef_r[e] <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= (state_r == ST_SWEEP);
      fin_vld_r <= rd_vld_r && (rd_j_r == LAST_J);
      if (state_r == ST_SWEEP) begin
        if (j_r == LAST_J) begin
          j_r   <= '0;
          lay_r <= lay_r + 4'd1;
        end else begin
          j_r <= j_r + 4'd1;
        end
      end else begin
        lay_r <= '0;
        j_r   <= '0;
      end
      for (int e = 0; e < NUM_ENTRY; e++) begin
        if (fin_vld_r && (fin_lay_r == 4'(e / NUM_COEF))) coef_r[e] <= rnd[e % NUM_COEF];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_lay_r <= lay_r;
    rd_j_r   <= j_r;
    if (rd_vld_r) begin
      for (int k = 0; k < NUM_COEF; k++) acc_r[k] <= acc_nxt[k];
      if (rd_j_r == LAST_J) begin
        for (int k = 0; k < NUM_COEF; k++) fin_r[k] <= acc_nxt[k];
        fin_lay_r <= rd_lay_r;
      end
    end
  end

  // ---------------------------------------------------------------- entry stage
  s64_t t_r, a_r, b_r, c_r;
  s64_t u_d [U_DLY];
  s64_t v_d [U_DLY];
  s64_t w64;
  assign w64 = s64_t'(in_w);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r    <= (w64 <<< 1) + w64;
      a_r    <= (w64 <<< 1) + w64 - (ONE <<< 1) - ONE;
      b_r    <= (w64 <<< 1) + w64 - (ONE <<< 1);
      c_r    <= (w64 <<< 1) + w64 - ONE;
      u_d[0] <= s64_t'(in_u);
      v_d[0] <= s64_t'(in_v);
      for (int i = 1; i < U_DLY; i++) begin
        u_d[i] <= u_d[i-1];
        v_d[i] <= v_d[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- w weights
  s64_t td_r [4];
  s64_t cd_r [4];
  s64_t ab, ac, bc;
  logic ab_o, ac_o, bc_o;
  s64_t x [4];
  logic xo [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      td_r[0] <= t_r;
      cd_r[0] <= c_r;
      for (int i = 1; i < 4; i++) begin
        td_r[i] <= td_r[i-1];
        cd_r[i] <= cd_r[i-1];
      end
    end
  end

  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_ab (
    .clk(clk), .en(adv), .a(a_r), .b(b_r), .ov_in(1'b0), .p(ab), .ov_out(ab_o));
  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_ac (
    .clk(clk), .en(adv), .a(a_r), .b(c_r), .ov_in(1'b0), .p(ac), .ov_out(ac_o));
  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_bc (
    .clk(clk), .en(adv), .a(b_r), .b(c_r), .ov_in(1'b0), .p(bc), .ov_out(bc_o));
  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_x0 (
    .clk(clk), .en(adv), .a(ab), .b(cd_r[3]), .ov_in(ab_o), .p(x[0]), .ov_out(xo[0]));
  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_x1 (
    .clk(clk), .en(adv), .a(ab), .b(td_r[3]), .ov_in(1'b0), .p(x[1]), .ov_out(xo[1]));
  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_x2 (
    .clk(clk), .en(adv), .a(ac), .b(td_r[3]), .ov_in(ac_o), .p(x[2]), .ov_out(xo[2]));
  cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_x3 (
    .clk(clk), .en(adv), .a(bc), .b(td_r[3]), .ov_in(bc_o), .p(x[3]), .ov_out(xo[3]));

  // divide by six for the end weights, by two for the middle ones; six is a halving,
  // then a shift-add multiply by 0x5555...5 and one compare to fix the low quotient
  logic [63:0]  dn0    [2];
  logic [63:0]  dn_r   [2][DIV_ST+1];
  logic [127:0] dp_r   [2][DIV_ST+1];
  logic [127:0] dp_nxt [2][DIV_ST];
  logic [63:0]  dq_r    [2][DIV_ST+1];
  logic         dneg_r  [4][DIV_ST+1];
  logic         dov_r   [DIV_ST+1];
  logic [63:0]  xm [4];
  s64_t         wt_r [NUM_LAYERS];
  logic         wov_r;

  always_comb begin
    for (int k = 0; k < 4; k++) xm[k] = x[k][63] ? 64'(-x[k]) : 64'(x[k]);
    dn0[0] = 64'(({1'b0, xm[0]} + 65'd3) >> 1);
    dn0[1] = 64'(({1'b0, xm[3]} + 65'd3) >> 1);
    for (int i = 0; i < 2; i++) begin
      for (int s = 0; s < DIV_ST; s++) begin
        if (s < 5) begin
          dp_nxt[i][s] = dp_r[i][s] + (dp_r[i][s] << (2 << s));
        end else if (s == 5) begin
          dp_nxt[i][s] = {64'd0, dp_r[i][s][127:64]};
        end else if (s == 6) begin
          dp_nxt[i][s] = {64'(dp_r[i][s][63:0] + (dp_r[i][s][63:0] << 1)),
                          dp_r[i][s][63:0]};
        end else begin
          dp_nxt[i][s] = {64'd0, ((dn_r[i][s] - dp_r[i][s][127:64]) >= 64'd3)
                                 ? dp_r[i][s][63:0] + 64'd1 : dp_r[i][s][63:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        dn_r[i][0] <= dn0[i];
        dp_r[i][0] <= {64'd0, dn0[i]};
      end
      dq_r[0][0]   <= 64'(({1'b0, xm[1]} + 65'd1) >> 1);
      dq_r[1][0]   <= 64'(({1'b0, xm[2]} + 65'd1) >> 1);
      for (int k = 0; k < 4; k++) dneg_r[k][0] <= x[k][63];
      dov_r[0] <= xo[0] | xo[1] | xo[2] | xo[3];
      for (int s = 1; s <= DIV_ST; s++) begin
        for (int i = 0; i < 2; i++) begin
          dn_r[i][s] <= dn_r[i][s-1];
          dp_r[i][s] <= dp_nxt[i][s-1];
          dq_r[i][s] <= dq_r[i][s-1];
        end
        for (int k = 0; k < 4; k++) dneg_r[k][s] <= dneg_r[k][s-1];
        dov_r[s] <= dov_r[s-1];
      end
      // weights 0 and 2 carry a negation
      wt_r[0] <= dneg_r[0][DIV_ST] ? $signed(dp_r[0][DIV_ST][63:0])
                                   : -$signed(dp_r[0][DIV_ST][63:0]);
      wt_r[1] <= dneg_r[1][DIV_ST] ? -$signed(dq_r[0][DIV_ST]) : $signed(dq_r[0][DIV_ST]);
      wt_r[2] <= dneg_r[2][DIV_ST] ? $signed(dq_r[1][DIV_ST]) : -$signed(dq_r[1][DIV_ST]);
      wt_r[3] <= dneg_r[3][DIV_ST] ? -$signed(dp_r[1][DIV_ST][63:0])
                                   : $signed(dp_r[1][DIV_ST][63:0]);
      wov_r   <= dov_r[DIV_ST];
    end
  end

  // ---------------------------------------------------------------- layer lanes
  s64_t lane_p  [NUM_LANES];
  logic lane_ov [NUM_LANES];

  for (genvar ln = 0; ln < NUM_LANES; ln++) begin : g_lane
    s64_t c [NUM_COEF];
    s64_t m6, m7, m8, m9;
    logic m6o, m7o, m8o, m9o;
    sat_t s_uu1, s_uv, s_vv, s_uu;
    s64_t uu1_r, uv_r, vv_r, m7d_r, uu_r, uvb_r, vvb_r;
    logic ova_r, ovb_r;
    s64_t p1, p2, p3;
    logic p1o, p2o, p3o;
    sat_t s_in1, s_vp, s_inner;
    s64_t in1_r, vp_r, p2d_r, inner_r, vpb_r;
    logic ova2_r, ovb2_r;
    s64_t q1, q2;
    logic q1o, q2o;
    sat_t s_val1, s_val;
    s64_t val1_r, q2d_r, val_r;
    logic ova3_r, ovb3_r;

    for (genvar k = 0; k < NUM_COEF; k++) begin : g_c
      assign c[k] = s64_t'(coef_r[ln*NUM_COEF + k]);
    end

    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_m6 (
      .clk(clk), .en(adv), .a(c[6]), .b(u_d[0]), .ov_in(1'b0), .p(m6), .ov_out(m6o));
    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_m7 (
      .clk(clk), .en(adv), .a(c[7]), .b(v_d[0]), .ov_in(1'b0), .p(m7), .ov_out(m7o));
    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_m8 (
      .clk(clk), .en(adv), .a(c[8]), .b(v_d[0]), .ov_in(1'b0), .p(m8), .ov_out(m8o));
    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_m9 (
      .clk(clk), .en(adv), .a(c[9]), .b(v_d[0]), .ov_in(1'b0), .p(m9), .ov_out(m9o));

    assign s_uu1 = sat_add(c[3], m6);
    assign s_uv  = sat_add(c[4], m8);
    assign s_vv  = sat_add(c[5], m9);
    assign s_uu  = sat_add(uu1_r, m7d_r);

    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_p1 (
      .clk(clk), .en(adv), .a(uu_r), .b(u_d[6]), .ov_in(ovb_r), .p(p1), .ov_out(p1o));
    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_p2 (
      .clk(clk), .en(adv), .a(uvb_r), .b(v_d[6]), .ov_in(1'b0), .p(p2), .ov_out(p2o));
    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_p3 (
      .clk(clk), .en(adv), .a(vvb_r), .b(v_d[6]), .ov_in(1'b0), .p(p3), .ov_out(p3o));

    assign s_in1   = sat_add(c[1], p1);
    assign s_vp    = sat_add(c[2], p3);
    assign s_inner = sat_add(in1_r, p2d_r);

    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_q1 (
      .clk(clk), .en(adv), .a(inner_r), .b(u_d[12]), .ov_in(ovb2_r), .p(q1), .ov_out(q1o));
    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_q2 (
      .clk(clk), .en(adv), .a(vpb_r), .b(v_d[12]), .ov_in(1'b0), .p(q2), .ov_out(q2o));

    assign s_val1 = sat_add(c[0], q1);
    assign s_val  = sat_add(val1_r, q2d_r);

    always_ff @(posedge clk) begin
      if (adv) begin
        uu1_r   <= s_uu1.v;
        uv_r    <= s_uv.v;
        vv_r    <= s_vv.v;
        m7d_r   <= m7;
        ova_r   <= m6o | m7o | m8o | m9o | s_uu1.ov | s_uv.ov | s_vv.ov;
        uu_r    <= s_uu.v;
        uvb_r   <= uv_r;
        vvb_r   <= vv_r;
        ovb_r   <= ova_r | s_uu.ov;
        in1_r   <= s_in1.v;
        vp_r    <= s_vp.v;
        p2d_r   <= p2;
        ova2_r  <= p1o | p2o | p3o | s_in1.ov | s_vp.ov;
        inner_r <= s_inner.v;
        vpb_r   <= vp_r;
        ovb2_r  <= ova2_r | s_inner.ov;
        val1_r  <= s_val1.v;
        q2d_r   <= q2;
        ova3_r  <= q1o | q2o | s_val1.ov;
        val_r   <= s_val.v;
        ovb3_r  <= ova3_r | s_val.ov;
      end
    end

    cppm_mul_shift #(.FRAC(PARAM_FRAC_BITS)) u_blend (
      .clk(clk), .en(adv), .a(val_r), .b(wt_r[ln % NUM_LAYERS]), .ov_in(ovb3_r | wov_r),
      .p(lane_p[ln]), .ov_out(lane_ov[ln]));
  end

  // ---------------------------------------------------------------- axis sums
  logic signed [31:0] coord_r [NUM_AXES];
  logic               ovf_r   [NUM_AXES];

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    sat_t s1, s2, s3;
    s64_t s1_r, s2_r, s3_r, p2d_r, p3d_r, p3dd_r;
    logic ova_r, ovb_r, ovc_r;

    assign s1 = sat_add(lane_p[ax*NUM_LAYERS], lane_p[ax*NUM_LAYERS + 1]);
    assign s2 = sat_add(s1_r, p2d_r);
    assign s3 = sat_add(s2_r, p3dd_r);

    always_ff @(posedge clk) begin
      if (adv) begin
        s1_r   <= s1.v;
        p2d_r  <= lane_p[ax*NUM_LAYERS + 2];
        p3d_r  <= lane_p[ax*NUM_LAYERS + 3];
        ova_r  <= lane_ov[ax*NUM_LAYERS] | lane_ov[ax*NUM_LAYERS + 1]
                  | lane_ov[ax*NUM_LAYERS + 2] | lane_ov[ax*NUM_LAYERS + 3] | s1.ov;
        s2_r   <= s2.v;
        p3dd_r <= p3d_r;
        ovb_r  <= ova_r | s2.ov;
        s3_r   <= s3.v;
        ovc_r  <= ovb_r | s3.ov;
        // clamp to 32 bits
        if (!s3_r[63] && (s3_r[62:31] != '0)) begin
          coord_r[ax] <= 32'sh7fffffff;
          ovf_r[ax]   <= 1'b1;
        end else if (s3_r[63] && (s3_r[62:31] != '1)) begin
          coord_r[ax] <= 32'sh80000000;
          ovf_r[ax]   <= 1'b1;
        end else begin
          coord_r[ax] <= s3_r[31:0];
          ovf_r[ax]   <= ovc_r;
        end
      end
    end
  end

  assign out_tdata = {coord_r[2], coord_r[1], coord_r[0]};
  assign out_tuser = ovf_r[0] | ovf_r[1] | ovf_r[2];

  // ---------------------------------------------------------------- checks
  a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld_r |-> (vld_r == '0))
    else $error("coefficient write while evaluations in flight");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input taken during commit");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && $past(state_r == ST_IDLE) |-> !fin_vld_r && !rd_vld_r)
    else $error("commit sequencer active while idle");

endmodule

[test/cppm_checker.sv]
// Point mapper scoreboard: predicts each evaluate from observed transfers and compares results.
module cppm_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tuser,
  output int           errors,
  output int           pending
);
  import cppm_pkg::*;

  localparam int FRAC = 30;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ov;
  } point_t;

  s64_t   nodes [NUM_AXES*NUM_NODES];
  s64_t   coefs [NUM_ENTRY];
  point_t mapped_q [$];

  function automatic logic [63:0] mag(input s64_t x);
    return x[63] ? -x : x;
  endfunction

  function automatic s64_t div_near(input s64_t x, input logic [63:0] d);
    logic [63:0] q;
    q = (mag(x) + d / 2) / d;
    return x[63] ? -q : q;
  endfunction

  function automatic s64_t add_sat(input s64_t a, input s64_t b, inout bit ov);
    s64_t s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) begin
      ov = 1;
      return {1'b0, {63{1'b1}}};
    end
    if (a[63] && b[63] && !s[63]) begin
      ov = 1;
      return {1'b1, 63'd0};
    end
    return s;
  endfunction

  function automatic s64_t mul_fix(input s64_t a, input s64_t b, inout bit ov);
    logic [127:0] p, q, lim;
    bit neg;
    neg = a[63] ^ b[63];
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    q = (p + (128'd1 << (FRAC - 1))) >> FRAC;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    if (q > lim) begin
      ov = 1;
      return neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  task automatic build_coefs();
    s64_t acc;
    for (int ax = 0; ax < NUM_AXES; ax++)
      for (int ly = 0; ly < NUM_LAYERS; ly++)
        for (int k = 0; k < NUM_COEF; k++) begin
          acc = 0;
          for (int j = 0; j < NUM_COEF; j++)
            acc += s64_t'(TWICE_W[k][j]) * nodes[ax*NUM_NODES + LAYER_NODES[ly][j]];
          coefs[(ax*NUM_LAYERS + ly)*NUM_COEF + k] = div_near(acc, 2);
        end
  endtask

  function automatic s64_t layer_cubic(input int base, input s64_t u, input s64_t v,
                                       inout bit ov);
    s64_t c [NUM_COEF];
    s64_t uu, uv, vv, inner, vpart;
    for (int k = 0; k < NUM_COEF; k++) c[k] = coefs[base + k];
    uu = add_sat(add_sat(c[3], mul_fix(c[6], u, ov), ov), mul_fix(c[7], v, ov), ov);
    uv = add_sat(c[4], mul_fix(c[8], v, ov), ov);
    inner = add_sat(add_sat(c[1], mul_fix(uu, u, ov), ov), mul_fix(uv, v, ov), ov);
    vv = add_sat(c[5], mul_fix(c[9], v, ov), ov);
    vpart = add_sat(c[2], mul_fix(vv, v, ov), ov);
    return add_sat(add_sat(c[0], mul_fix(inner, u, ov), ov), mul_fix(vpart, v, ov), ov);
  endfunction

  function automatic point_t map_point(input s64_t u, input s64_t v, input s64_t w);
    point_t r;
    bit ov;
    s64_t one, t, a, b, c, ab, sum;
    s64_t wt [NUM_LAYERS];
    s64_t res [NUM_AXES];
    ov = 0;
    one = s64_t'(1) <<< FRAC;
    t = 3 * w;
    a = t - 3 * one;
    b = t - 2 * one;
    c = t - one;
    ab = mul_fix(a, b, ov);
    wt[0] = -div_near(mul_fix(ab, c, ov), 6);
    wt[1] = div_near(mul_fix(ab, t, ov), 2);
    wt[2] = -div_near(mul_fix(mul_fix(a, c, ov), t, ov), 2);
    wt[3] = div_near(mul_fix(mul_fix(b, c, ov), t, ov), 6);
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      sum = 0;
      for (int ly = 0; ly < NUM_LAYERS; ly++)
        sum = add_sat(sum, mul_fix(layer_cubic((ax*NUM_LAYERS + ly)*NUM_COEF, u, v, ov),
                                   wt[ly], ov), ov);
      if (sum > 64'sh7FFFFFFF) begin
        sum = 64'sh7FFFFFFF;
        ov = 1;
      end
      if (sum < -64'sh80000000) begin
        sum = -64'sh80000000;
        ov = 1;
      end
      res[ax] = sum;
    end
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
    r.ov = ov;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < NUM_ENTRY; i++) coefs[i] = 0;
    for (int i = 0; i < NUM_AXES*NUM_NODES; i++) nodes[i] = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      case (in_tuser)
        CMD_LOAD:
          if (in_tdata[5:0] < NUM_NODES && in_tdata[7:6] < NUM_AXES)
            nodes[in_tdata[7:6]*NUM_NODES + in_tdata[5:0]] = s64_t'($signed(in_tdata[39:8]));
        CMD_COMMIT: build_coefs();
        CMD_EVAL:
          mapped_q.push_back(map_point(s64_t'($signed(in_tdata[71:40])),
                                       s64_t'($signed(in_tdata[103:72])),
                                       s64_t'($signed(in_tdata[135:104]))));
        default: ;
      endcase
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (mapped_q.size() == 0) begin
        report("result transfer with no evaluate outstanding");
      end else begin
        point_t e;
        e = mapped_q.pop_front();
        if (out_tdata[31:0] !== e.x)
          report($sformatf("coord_x got %h want %h", out_tdata[31:0], e.x));
        if (out_tdata[63:32] !== e.y)
          report($sformatf("coord_y got %h want %h", out_tdata[63:32], e.y));
        if (out_tdata[95:64] !== e.z)
          report($sformatf("coord_z got %h want %h", out_tdata[95:64], e.z));
        if (out_tuser !== e.ov)
          report($sformatf("overflow got %b want %b", out_tuser, e.ov));
      end
    end
    pending = mapped_q.size();
  end
endmodule

[test/testbench.sv]
// Top of the point mapper bench: clock, reset, stimulus, output stalls and verdict.
module testbench;
  import cppm_pkg::*;

  localparam int ITEMS = 1550;
  localparam int QUIET_FROM = 1300;
  localparam int LIMIT = 400000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = CMD_LOAD;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [95:0]  out_tdata;
  logic         out_tuser;
  int           errors, pending;
  int           cycles = 0;
  bit           quiet = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  cubic_prism_point_mapper dut (.*);

  cppm_checker scoreboard (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL cubic_prism_point_mapper");
      $finish;
    end
  end

  // output stalls in bursts, none in the closing stretch
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 8) - 1) @(posedge clk);
      end else begin
        out_tready <= 1;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end
    end
  end

  task automatic push(input logic [1:0] cmd, input logic [5:0] node, input logic [1:0] axis,
                      input logic [31:0] val, input logic [31:0] u, input logic [31:0] v,
                      input logic [31:0] w);
    bit rdy;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {w, v, u, val, axis, node};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  function automatic logic [31:0] rand_param();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 2 * 1342177280) - 1342177280;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 2 * 13107200) - 13107200;
  endfunction

  // hold the input idle until every outstanding result has left
  task automatic drain();
    in_tvalid <= 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  localparam logic [31:0] PMAX = 32'h7FFFFFFF, PMIN = 32'h80000000;
  localparam logic [31:0] W_THIRD = 32'd357913941, W_TWO3 = 32'd715827883;
  localparam logic [31:0] W_ONE = 32'h40000000;

  initial begin
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // evaluate against the cleared coefficients
    push(CMD_EVAL, 0, 0, 0, PMAX, PMIN, W_ONE);
    push(CMD_EVAL, 0, 0, 0, PMIN, PMAX, PMIN);
    // fill every node, the extremes on a few
    for (int a = 0; a < NUM_AXES; a++)
      for (int n = 0; n < NUM_NODES; n++)
        push(CMD_LOAD, 6'(n), 2'(a), n == 0 ? PMAX : n == 3 ? PMIN : rand_coord(), 0, 0, 0);
    push(CMD_LOAD, 6'd63, 0, PMAX, 0, 0, 0);
    push(CMD_LOAD, 6'd5, 2'd3, PMIN, 0, 0, 0);
    push(CMD_UNKNOWN, 6'd63, 2'd3, PMAX, PMAX, PMAX, PMAX);
    push(CMD_COMMIT, 0, 0, 0, 0, 0, 0);
    push(CMD_EVAL, 0, 0, 0, 0, 0, 0);
    push(CMD_EVAL, 0, 0, 0, W_ONE, 0, W_THIRD);
    push(CMD_EVAL, 0, 0, 0, 0, W_ONE, W_TWO3);
    push(CMD_EVAL, 0, 0, 0, PMAX, PMAX, W_ONE);
    push(CMD_EVAL, 0, 0, 0, PMIN, PMIN, PMIN);
    push(CMD_EVAL, 0, 0, 0, 32'hFFFFFFFF, 32'h1, PMAX);
    // tame nodes so most points stay in range
    for (int a = 0; a < NUM_AXES; a++) begin
      push(CMD_LOAD, 0, 2'(a), 0, 0, 0, 0);
      push(CMD_LOAD, 3, 2'(a), 32'h00010000, 0, 0, 0);
    end
    push(CMD_COMMIT, 0, 0, 0, 0, 0, 0);
    drain();

    for (int i = 0; i < ITEMS; i++) begin
      if (i == QUIET_FROM) quiet = 1;
      if (i == ITEMS / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 22)
        push(CMD_LOAD, 6'($urandom_range(0, NUM_NODES - 1)),
             2'($urandom_range(0, NUM_AXES - 1)), rand_coord(), $urandom, $urandom, $urandom);
      else if (r < 25)
        push(CMD_LOAD, 6'($urandom_range(NUM_NODES, 63)), 2'($urandom_range(0, 3)), $urandom,
             $urandom, $urandom, $urandom);
      else if (r < 27)
        push(CMD_LOAD, 6'($urandom_range(0, 63)), 2'd3, $urandom, $urandom, $urandom,
             $urandom);
      else if (r < 29)
        push(CMD_UNKNOWN, 6'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
             $urandom);
      else if (r < 32)
        push(CMD_COMMIT, 6'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
             $urandom);
      else
        push(CMD_EVAL, 6'($urandom), 2'($urandom), $urandom, rand_param(), rand_param(),
             rand_param());
    end
    in_tvalid <= 0;
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS cubic_prism_point_mapper");
    else
      $display("FAIL cubic_prism_point_mapper");
    $finish;
  end
endmodule

[files.f]
design/cppm_pkg.sv
design/cppm_ram.sv
design/cppm_mul_shift.sv
design/cubic_prism_point_mapper.sv
test/cppm_checker.sv
test/testbench.sv
